// File: design/turbo_encoder_qpp_unit_defines.svh
// Assertion macros shared by the checker of the turbo encoder.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TURBO_ENCODER_QPP_UNIT_DEFINES_SVH
`define TURBO_ENCODER_QPP_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tec_pkg.sv
// Package of the QPP turbo encoder: widths, codes, handshake structs and
// the constituent encoder functions. No dependencies.
package tec_pkg;

  localparam int CNT_W  = 13;          // counters and block size
  localparam int COEF_W = 10;          // interleaver coefficients
  localparam int MOD_W  = 14;          // dividend of the modulo unit
  localparam int SH_W   = 4;           // shift count of the modulo unit
  localparam int WIDE_W = MOD_W + CNT_W;
  localparam int TAIL_W = 12;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_BLOCK_SIZE = 2'd0;
  localparam cfg_idx_t REG_COEFF_ONE  = 2'd1;
  localparam cfg_idx_t REG_COEFF_TWO  = 2'd2;

  // Item function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  // Request to and response from the modulo unit.
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] x;
    logic [CNT_W-1:0] k;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] r;
  } mod_rsp_t;

  // One step of a constituent encoder: feedback 1+D2+D3, parity 1+D+D3.
  // Returns {next registers, parity}.
  function automatic logic [3:0] enc_step(logic [2:0] regs, logic u);
    logic a;
    a = u ^ regs[1] ^ regs[2];
    return {regs[1], regs[0], a, a ^ regs[0] ^ regs[2]};
  endfunction

  // Three termination steps. Returns {final registers, x0 z0 x1 z1 x2 z2}.
  function automatic logic [8:0] enc_tail(logic [2:0] regs);
    logic [2:0] r;
    logic [5:0] acc;
    logic       x;
    logic [3:0] s;
    r   = regs;
    acc = '0;
    for (int n = 0; n < 3; n++) begin
      x   = r[1] ^ r[2];
      s   = enc_step(r, x);
      r   = s[3:1];
      acc = {acc[3:0], x, s[0]};
    end
    return {r, acc};
  endfunction

endpackage

// File: design/tec_if.sv
// Handshake interfaces of the turbo encoder: input items, result triples
// and configuration writes. Depends on tec_pkg.
interface tec_in_if;
  logic valid;
  logic ready;
  logic func;
  logic data_bit;

  modport source (output valid, output func, output data_bit, input ready);
  modport sink (input valid, input func, input data_bit, output ready);
endinterface

interface tec_out_if;
  logic valid;
  logic ready;
  logic coded_bit_a;
  logic coded_bit_b;
  logic coded_bit_c;
  logic tail_group;
  logic last_group;

  modport source (output valid, output coded_bit_a, output coded_bit_b,
                  output coded_bit_c, output tail_group, output last_group,
                  input ready);
  modport sink (input valid, input coded_bit_a, input coded_bit_b,
                input coded_bit_c, input tail_group, input last_group,
                output ready);
endinterface

interface tec_cfg_if;
  import tec_pkg::*;
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [CNT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/tec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tec_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/tec_qpp_mod.sv
// Iterative modulo unit for the interleaver recurrences: x mod k, one
// conditional subtract per cycle, with a short path for x below 2k.
// Depends on tec_pkg.
module tec_qpp_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tec_pkg::mod_req_t req_i,
  output tec_pkg::mod_rsp_t rsp_o
);
  import tec_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_CHECK, M_STEP} mod_state_e;

  mod_state_e        state_q, state_d;
  logic [MOD_W-1:0]  r_q, r_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [SH_W-1:0]   sh_q, sh_d;
  logic              done_q, done_d;
  logic [WIDE_W-1:0] kshift;
  logic [MOD_W-1:0]  k_ext;
  logic [MOD_W-1:0]  k_dbl;

  assign k_ext  = MOD_W'(k_q);
  assign k_dbl  = {k_q, 1'b0};
  assign kshift = WIDE_W'(k_q) << sh_q;

  // Next-state logic: a quick check first, then a restoring reduction
  // from the top shift down to zero.
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    k_d     = k_q;
    sh_d    = sh_q;
    done_d  = 1'b0;
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          r_d     = req_i.x;
          k_d     = req_i.k;
          state_d = M_CHECK;
        end
      end
      M_CHECK: begin
        if (r_q < k_ext) begin
          done_d  = 1'b1;
          state_d = M_IDLE;
        end else if (r_q < k_dbl) begin
          r_d     = r_q - k_ext;
          done_d  = 1'b1;
          state_d = M_IDLE;
        end else begin
          sh_d    = SH_W'(MOD_W - 1);
          state_d = M_STEP;
        end
      end
      M_STEP: begin
        if (WIDE_W'(r_q) >= kshift) begin
          r_d = r_q - kshift[MOD_W-1:0];
        end
        if (sh_q == '0) begin
          done_d  = 1'b1;
          state_d = M_IDLE;
        end else begin
          sh_d = sh_q - SH_W'(1);
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      r_q     <= '0;
      k_q     <= '0;
      sh_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      k_q     <= k_d;
      sh_q    <= sh_d;
      done_q  <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.r    = r_q[CNT_W-1:0];

endmodule

// File: design/turbo_encoder_qpp_unit.sv
// Rate-1/3 QPP turbo encoder. The load beat that completes a block adds
// one modulo reduction. A data pull gives its triple through the S_EMIT
// state and the output register, then two reductions run in the shared
// modulo unit before the next beat is taken; tail pulls need none. Reset
// clears all control state and loads the register reset values; the block
// store is not cleared. Depends on tec_pkg, tec_if, tec_ram, tec_qpp_mod.
module turbo_encoder_qpp_unit #(
  parameter int MAX_BLOCK = 6144
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tec_in_if.sink    in_i,
  tec_out_if.source out_o,
  tec_cfg_if.sink   cfg_i
);
  import tec_pkg::*;

  localparam int AW = $clog2(MAX_BLOCK);
  localparam logic [CNT_W-1:0] MaxBlk = CNT_W'(MAX_BLOCK);

  typedef enum logic [1:0] {PH_LOAD, PH_DATA, PH_TAIL} phase_e;
  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_MOD_PERM, S_MOD_STEP} state_e;

  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    blk_size_q, blk_size_d;
  logic [COEF_W-1:0]   coef_one_q, coef_one_d;
  logic [COEF_W-1:0]   coef_two_q, coef_two_d;
  logic [CNT_W-1:0]    load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0]    drain_q, drain_d;
  logic [CNT_W-1:0]    perm_q, perm_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [2:0]          upper_q, upper_d;
  logic [2:0]          lower_q, lower_d;
  logic [TAIL_W-1:0]   tail_q, tail_d;
  logic                out_valid_q, out_valid_d;
  logic                out_a_q, out_a_d;
  logic                out_b_q, out_b_d;
  logic                out_c_q, out_c_d;
  logic                out_tail_q, out_tail_d;
  logic                out_last_q, out_last_d;

  logic [CNT_W-1:0]    k_eff;
  logic [CNT_W-1:0]    load_inc;
  logic                in_beat;
  logic                ram_we;
  logic                bit_sys;
  logic                bit_perm;
  logic [3:0]          up_step;
  logic [3:0]          lo_step;
  logic [8:0]          up_tail;
  logic [8:0]          lo_tail;
  logic [TAIL_W-1:0]   tail_src;
  logic [CNT_W-1:0]    tail_idx;
  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  // Effective block size, clamped to the supported range.
  always_comb begin
    if (blk_size_q == '0) begin
      k_eff = CNT_W'(1);
    end else if (blk_size_q > MaxBlk) begin
      k_eff = MaxBlk;
    end else begin
      k_eff = blk_size_q;
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_beat     = in_i.valid && in_i.ready;
  assign load_inc    = load_cnt_q + CNT_W'(1);

  // Two copies of the block store give the systematic and interleaved
  // reads in the same cycle. Reads are issued on the pull beat, and no
  // write can occur until the data phase has ended.
  tec_ram #(.WIDTH(1), .DEPTH(MAX_BLOCK)) u_ram_sys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i (in_i.data_bit),
    .raddr_i (drain_q[AW-1:0]),
    .rdata_o (bit_sys)
  );

  tec_ram #(.WIDTH(1), .DEPTH(MAX_BLOCK)) u_ram_perm (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i (in_i.data_bit),
    .raddr_i (perm_q[AW-1:0]),
    .rdata_o (bit_perm)
  );

  tec_qpp_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Encoder steps and termination sequences.
  assign up_step  = enc_step(upper_q, bit_sys);
  assign lo_step  = enc_step(lower_q, bit_perm);
  assign up_tail  = enc_tail(upper_q);
  assign lo_tail  = enc_tail(lower_q);
  assign tail_src = (phase_q == PH_DATA) ? {up_tail[5:0], lo_tail[5:0]} : tail_q;
  assign tail_idx = (phase_q == PH_DATA) ? '0 : drain_q;

  // Configuration writes.
  always_comb begin
    blk_size_d = blk_size_q;
    coef_one_d = coef_one_q;
    coef_two_d = coef_two_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_BLOCK_SIZE: blk_size_d = cfg_i.data;
        REG_COEFF_ONE:  coef_one_d = cfg_i.data[COEF_W-1:0];
        REG_COEFF_TWO:  coef_two_d = cfg_i.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: loading, emitting triples and the interleaver updates.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    load_cnt_d  = load_cnt_q;
    drain_d     = drain_q;
    perm_d      = perm_q;
    step_d      = step_q;
    upper_d     = upper_q;
    lower_d     = lower_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_c_d     = out_c_q;
    out_tail_d  = out_tail_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    mod_req     = '0;
    mod_req.k   = k_eff;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (in_i.func == FUNC_LOAD) begin
            if (phase_q == PH_LOAD) begin
              ram_we     = (load_cnt_q < MaxBlk);
              load_cnt_d = load_inc;
              if (load_inc >= k_eff) begin
                phase_d       = PH_DATA;
                drain_d       = '0;
                perm_d        = '0;
                mod_req.start = 1'b1;
                mod_req.x     = MOD_W'(coef_one_q) + MOD_W'(coef_two_q);
                state_d       = S_MOD_STEP;
              end
            end
          end else if (phase_q != PH_LOAD) begin
            state_d = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          if (phase_q == PH_DATA && drain_q < k_eff) begin
            // Data triple.
            out_a_d       = bit_sys;
            out_b_d       = up_step[0];
            out_c_d       = lo_step[0];
            out_tail_d    = 1'b0;
            out_last_d    = 1'b0;
            upper_d       = up_step[3:1];
            lower_d       = lo_step[3:1];
            drain_d       = drain_q + CNT_W'(1);
            mod_req.start = 1'b1;
            mod_req.x     = MOD_W'(perm_q) + MOD_W'(step_q);
            state_d       = S_MOD_PERM;
          end else begin
            // Tail triple; the first one also runs the termination.
            out_a_d    = tail_src[11];
            out_b_d    = tail_src[10];
            out_c_d    = tail_src[9];
            out_tail_d = 1'b1;
            tail_d     = {tail_src[8:0], 3'b000};
            if (phase_q == PH_DATA) begin
              upper_d = up_tail[8:6];
              lower_d = lo_tail[8:6];
              phase_d = PH_TAIL;
            end
            if (tail_idx >= CNT_W'(3)) begin
              out_last_d = 1'b1;
              phase_d    = PH_LOAD;
              load_cnt_d = '0;
              drain_d    = '0;
              perm_d     = '0;
              step_d     = '0;
              upper_d    = '0;
              lower_d    = '0;
              tail_d     = '0;
            end else begin
              out_last_d = 1'b0;
              drain_d    = tail_idx + CNT_W'(1);
            end
            state_d = S_IDLE;
          end
        end
      end

      S_MOD_PERM: begin
        if (mod_rsp.done) begin
          perm_d        = mod_rsp.r;
          mod_req.start = 1'b1;
          mod_req.x     = MOD_W'(step_q) + MOD_W'({coef_two_q, 1'b0});
          state_d       = S_MOD_STEP;
        end
      end

      S_MOD_STEP: begin
        if (mod_rsp.done) begin
          step_d  = mod_rsp.r;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, configuration and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_LOAD;
      blk_size_q  <= CNT_W'(40);
      coef_one_q  <= COEF_W'(3);
      coef_two_q  <= COEF_W'(10);
      load_cnt_q  <= '0;
      drain_q     <= '0;
      perm_q      <= '0;
      step_q      <= '0;
      upper_q     <= '0;
      lower_q     <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
      out_a_q     <= 1'b0;
      out_b_q     <= 1'b0;
      out_c_q     <= 1'b0;
      out_tail_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      blk_size_q  <= blk_size_d;
      coef_one_q  <= coef_one_d;
      coef_two_q  <= coef_two_d;
      load_cnt_q  <= load_cnt_d;
      drain_q     <= drain_d;
      perm_q      <= perm_d;
      step_q      <= step_d;
      upper_q     <= upper_d;
      lower_q     <= lower_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
      out_a_q     <= out_a_d;
      out_b_q     <= out_b_d;
      out_c_q     <= out_c_d;
      out_tail_q  <= out_tail_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.coded_bit_a = out_a_q;
  assign out_o.coded_bit_b = out_b_q;
  assign out_o.coded_bit_c = out_c_q;
  assign out_o.tail_group  = out_tail_q;
  assign out_o.last_group  = out_last_q;

endmodule

// File: design/tec_checker.sv
// Port-level checker of the turbo encoder, bound to the top level.
// Depends on tec_pkg and turbo_encoder_qpp_unit_defines.svh.
`include "turbo_encoder_qpp_unit_defines.svh"

module tec_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_func_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_a_i,
  input logic out_b_i,
  input logic out_c_i,
  input logic out_tail_i,
  input logic out_last_i
);
  import tec_pkg::*;

  logic       in_beat;
  logic       out_stall;
  logic [4:0] out_bits;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_bits  = {out_a_i, out_b_i, out_c_i, out_tail_i, out_last_i};

  // A stalled triple holds its bits.
  `TEC_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(out_bits), "stalled triple changed")

  // The closing triple of a block is always a termination triple.
  `TEC_ASSERT_IMP(a_last_is_tail, out_valid_i && out_last_i, out_tail_i, "last triple without tail flag")

  // The beat that causes a fresh triple is a pull, never a load.
  `TEC_ASSERT_IMP(a_out_pull, $rose(out_valid_i), $past(in_func_i, 2) == FUNC_PULL, "triple after a load")

  // A fresh triple only follows an accepted beat, via S_EMIT.
  `TEC_ASSERT_IMP(a_out_cause, $rose(out_valid_i), $past(in_beat, 2), "triple without a pull")

endmodule

bind turbo_encoder_qpp_unit tec_checker u_tec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_a_i     (out_o.coded_bit_a),
  .out_b_i     (out_o.coded_bit_b),
  .out_c_i     (out_o.coded_bit_c),
  .out_tail_i  (out_o.tail_group),
  .out_last_i  (out_o.last_group)
);
